### hw/rtl/mcled_pkg.sv
// Shared constants, codes and types of the multi-channel LED effect engine.
package mcled_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = 3;
    localparam int COLOR_W  = 8;
    localparam int RGB_W    = 3 * COLOR_W;
    localparam int MASK_W   = 8;
    localparam int PER_W    = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [PER_W-1:0]   BLINK_RESET = PER_W'(1000);
    localparam logic [PER_W-1:0]   PULSE_RESET = PER_W'(1800);
    localparam logic [PER_W-1:0]   MIN_PERIOD  = PER_W'(2);
    localparam logic [COLOR_W-1:0] FULL_SCALE  = COLOR_W'(255);

    // Item operation codes
    localparam logic [1:0] OP_SET_COLOR  = 2'd0;
    localparam logic [1:0] OP_SET_EFFECT = 2'd1;
    localparam logic [1:0] OP_TICK       = 2'd2;

    // Effect codes
    localparam logic [1:0] EFF_OFF   = 2'd0;
    localparam logic [1:0] EFF_SOLID = 2'd1;
    localparam logic [1:0] EFF_BLINK = 2'd2;
    localparam logic [1:0] EFF_PULSE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE = 2'd2;

    typedef enum logic [1:0] {
        DIV_BLINK,
        DIV_PULSE,
        DIV_LEVEL
    } t_div_sel;

    typedef struct packed {
        logic            accept;
        logic            div_start;
        t_div_sel        div_sel;
        logic            fold;
        logic            load_ch;
        logic            eval;
        logic            flush;
        logic [CH_W-1:0] idx;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
        logic ch_en;
        logic diff;
        logic pend_valid;
        logic out_free;
    } t_dp_stat;

endpackage

### hw/rtl/mcled_item_if.sv
// Input item channel: valid/ready handshake with the command or tick payload.
interface mcled_item_if;
    import mcled_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [CH_W-1:0]   target;
    logic              to_all;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
    logic [1:0]        effect_in;
    logic [TIME_W-1:0] now_ms;

    modport source (
        output valid, op, target, to_all, red_in, green_in, blue_in, effect_in, now_ms,
        input  ready
    );
    modport sink (
        input  valid, op, target, to_all, red_in, green_in, blue_in, effect_in, now_ms,
        output ready
    );
endinterface

### hw/rtl/mcled_result_if.sv
// Result channel: valid/ready handshake with one changed channel color.
interface mcled_result_if;
    import mcled_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
    logic               last;

    modport source (
        output valid, channel, red_out, green_out, blue_out, last,
        input  ready
    );
    modport sink (
        input  valid, channel, red_out, green_out, blue_out, last,
        output ready
    );
endinterface

### hw/rtl/multi_channel_led_effect_engine.sv
// Top level of the multi-channel LED effect engine.
// Set-color and set-effect items are applied in the cycle they transfer. A tick holds
// off the next item while it runs: three divisions on one shared bit-serial divider
// (each a start state, 32 steps and a wait for the done flag) give the blink phase,
// pulse phase and triangle level once per tick, a fold state folds the pulse phase,
// then the walk visits every channel to check its enable and adds an evaluate state
// on each enabled channel to scale and compare, in ascending order, and a closing
// flush state hands off the final result; a busy result port adds stalls. The newest
// changed color is held back in a pending register so the final result of a tick can
// carry last = 1. A new item is taken once the tick's walk is done, while its final
// result may still wait in the output register.
module multi_channel_led_effect_engine
    import mcled_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PER_W-1:0]     i_cfg_wdata,
    mcled_item_if.sink           i_item,
    mcled_result_if.source       o_result
);

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;
    logic      w_ready;

    assign i_item.ready = w_ready;

    mcled_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_op    (i_item.op),
        .o_ready (w_ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    mcled_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_item.op),
        .i_target    (i_item.target),
        .i_to_all    (i_item.to_all),
        .i_red       (i_item.red_in),
        .i_green     (i_item.green_in),
        .i_blue      (i_item.blue_in),
        .i_effect    (i_item.effect_in),
        .i_now       (i_item.now_ms),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_channel   (o_result.channel),
        .o_red       (o_result.red_out),
        .o_green     (o_result.green_out),
        .o_blue      (o_result.blue_out),
        .o_last      (o_result.last)
    );

endmodule

### hw/rtl/mcled_div.sv
// Restoring divider: one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
module mcled_div
    import mcled_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    input  logic [PER_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [TIME_W-1:0] o_quo,
    output logic [PER_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(TIME_W);

    logic [PER_W-1:0]  r_rem;
    logic [TIME_W-1:0] r_quo;
    logic [PER_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [PER_W:0]    w_trial;
    logic              w_ge;
    logic [PER_W:0]    w_diff;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        w_trial = {r_rem, r_quo[TIME_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    // Control: start, count steps, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[TIME_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[PER_W-1:0] : w_trial[PER_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

### hw/rtl/mcled_dp.sv
// Datapath: configuration, channel state, effect resolution and result registers.
module mcled_dp
    import mcled_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PER_W-1:0]     i_cfg_wdata,
    input  logic [1:0]           i_op,
    input  logic [CH_W-1:0]      i_target,
    input  logic                 i_to_all,
    input  logic [COLOR_W-1:0]   i_red,
    input  logic [COLOR_W-1:0]   i_green,
    input  logic [COLOR_W-1:0]   i_blue,
    input  logic [1:0]           i_effect,
    input  logic [TIME_W-1:0]    i_now,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CH_W-1:0]      o_channel,
    output logic [COLOR_W-1:0]   o_red,
    output logic [COLOR_W-1:0]   o_green,
    output logic [COLOR_W-1:0]   o_blue,
    output logic                 o_last
);

    localparam int PROD_W = 2 * COLOR_W;
    localparam int PH_W   = PER_W + COLOR_W;

    // Exact x / 255 for x up to 255 * 255, the largest product of two 8-bit values
    function automatic logic [COLOR_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + (PROD_W+1)'(1) + (PROD_W+1)'(x[PROD_W-1:COLOR_W]);
        return s[PROD_W-1:COLOR_W];
    endfunction

    // Configuration registers
    logic [MASK_W-1:0] r_mask;
    logic [PER_W-1:0]  r_blink_per;
    logic [PER_W-1:0]  r_pulse_per;

    // Per-channel state
    logic [RGB_W-1:0] r_base  [CHANNELS];
    logic [1:0]       r_mode  [CHANNELS];
    logic [RGB_W-1:0] r_shown [CHANNELS];

    // Tick-wide values
    logic [TIME_W-1:0]  r_now;
    t_div_sel           r_sel;
    logic [PER_W-1:0]   r_bph;
    logic [PER_W-1:0]   r_pph;
    logic [PH_W-1:0]    r_ph255;
    logic [COLOR_W-1:0] r_lvl;

    // Channel under evaluation
    logic [CH_W-1:0]    r_cidx;
    logic [RGB_W-1:0]   r_cbase;
    logic [1:0]         r_cmode;
    logic [RGB_W-1:0]   r_cshown;
    logic [PROD_W-1:0]  r_prod_r;
    logic [PROD_W-1:0]  r_prod_g;
    logic [PROD_W-1:0]  r_prod_b;

    // Held result and output register
    logic               r_pend_valid;
    logic [CH_W-1:0]    r_pend_ch;
    logic [RGB_W-1:0]   r_pend_color;
    logic               r_out_valid;
    logic [CH_W-1:0]    r_out_ch;
    logic [RGB_W-1:0]   r_out_color;
    logic               r_out_last;

    logic [PER_W-1:0]  w_bper;
    logic [PER_W-1:0]  w_pper;
    logic [PER_W-1:0]  w_bhalf;
    logic [PER_W-1:0]  w_phalf;
    logic [PER_W-1:0]  w_ph;
    logic [TIME_W-1:0] w_dividend;
    logic [PER_W-1:0]  w_divisor;
    logic              w_div_done;
    logic [TIME_W-1:0] w_quo;
    logic [PER_W-1:0]  w_rem;
    logic [RGB_W-1:0]  w_res;
    logic              w_diff;
    logic              w_out_free;
    logic [RGB_W-1:0]  w_sel_base;

    // Clamp periods and halve them
    always_comb begin
        w_bper  = (r_blink_per < MIN_PERIOD) ? MIN_PERIOD : r_blink_per;
        w_pper  = (r_pulse_per < MIN_PERIOD) ? MIN_PERIOD : r_pulse_per;
        w_bhalf = w_bper >> 1;
        w_phalf = w_pper >> 1;
        w_ph    = (r_pph >= w_phalf) ? (w_pper - r_pph) : r_pph;
    end

    // Select divider operands
    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_BLINK: begin
                w_dividend = r_now;
                w_divisor  = w_bper;
            end
            DIV_PULSE: begin
                w_dividend = r_now;
                w_divisor  = w_pper;
            end
            default: begin
                w_dividend = TIME_W'(r_ph255);
                w_divisor  = w_phalf;
            end
        endcase
    end

    mcled_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_blink_per <= BLINK_RESET;
            r_pulse_per <= PULSE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MASK:  r_mask      <= i_cfg_wdata[MASK_W-1:0];
                CFG_BLINK: r_blink_per <= i_cfg_wdata;
                CFG_PULSE: r_pulse_per <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Resolve the loaded channel color
    always_comb begin
        unique case (r_cmode)
            EFF_SOLID: w_res = r_cbase;
            EFF_BLINK: w_res = (r_bph < w_bhalf) ? r_cbase : '0;
            EFF_PULSE: w_res = {div255(r_prod_r), div255(r_prod_g), div255(r_prod_b)};
            default:   w_res = '0;
        endcase
        w_diff     = (w_res != r_cshown);
        w_out_free = !r_out_valid || i_out_ready;
        w_sel_base = r_base[i_cmd.idx];
    end

    // Apply commands, update shown colors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_base[i]  <= '0;
                r_mode[i]  <= EFF_OFF;
                r_shown[i] <= '1;
            end
        end else begin
            if (i_cmd.accept) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_mask[i] && (i_to_all || i_target == CH_W'(i))) begin
                        if (i_op == OP_SET_COLOR) begin
                            r_base[i] <= {i_red, i_green, i_blue};
                        end
                        if (i_op == OP_SET_EFFECT) begin
                            r_mode[i] <= i_effect;
                        end
                    end
                end
            end
            if (i_cmd.eval && w_diff) begin
                r_shown[r_cidx] <= w_res;
            end
        end
    end

    // Tick-wide phase and level values
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_op == OP_TICK) begin
            r_now <= i_now;
        end
        if (i_cmd.div_start) begin
            r_sel <= i_cmd.div_sel;
        end
        if (w_div_done) begin
            unique case (r_sel)
                DIV_BLINK: r_bph <= w_rem;
                DIV_PULSE: r_pph <= w_rem;
                default:   r_lvl <= (|w_quo[TIME_W-1:COLOR_W]) ? FULL_SCALE
                                                               : w_quo[COLOR_W-1:0];
            endcase
        end
        if (i_cmd.fold) begin
            r_ph255 <= {w_ph, {COLOR_W{1'b0}}} - PH_W'(w_ph);
        end
    end

    // Load one channel and scale its base color by the level
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ch) begin
            r_cidx   <= i_cmd.idx;
            r_cbase  <= w_sel_base;
            r_cmode  <= r_mode[i_cmd.idx];
            r_cshown <= r_shown[i_cmd.idx];
            r_prod_r <= PROD_W'(w_sel_base[RGB_W-1:2*COLOR_W]) * PROD_W'(r_lvl);
            r_prod_g <= PROD_W'(w_sel_base[2*COLOR_W-1:COLOR_W]) * PROD_W'(r_lvl);
            r_prod_b <= PROD_W'(w_sel_base[COLOR_W-1:0]) * PROD_W'(r_lvl);
        end
    end

    // Hold the newest change; push the older one out when another arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.eval && w_diff) begin
                r_pend_valid <= 1'b1;
                if (r_pend_valid) begin
                    r_out_valid <= 1'b1;
                end
            end else if (i_cmd.flush && r_pend_valid) begin
                r_pend_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && w_diff) begin
            r_pend_ch    <= r_cidx;
            r_pend_color <= w_res;
            if (r_pend_valid) begin
                r_out_ch    <= r_pend_ch;
                r_out_color <= r_pend_color;
                r_out_last  <= 1'b0;
            end
        end else if (i_cmd.flush && r_pend_valid) begin
            r_out_ch    <= r_pend_ch;
            r_out_color <= r_pend_color;
            r_out_last  <= 1'b1;
        end
    end

    always_comb begin
        o_stat.div_done   = w_div_done;
        o_stat.ch_en      = r_mask[i_cmd.idx];
        o_stat.diff       = w_diff;
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_channel   = r_out_ch;
    assign o_red       = r_out_color[RGB_W-1:2*COLOR_W];
    assign o_green     = r_out_color[2*COLOR_W-1:COLOR_W];
    assign o_blue      = r_out_color[COLOR_W-1:0];
    assign o_last      = r_out_last;

    // A change that displaces a held one sends it out as a non-final transfer
    a_push_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && w_diff && r_pend_valid) |=> (r_out_valid && !r_out_last))
        else $error("displaced result not presented as non-final");

    // Flushing the held change presents it as the final transfer
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.flush && r_pend_valid) |=> (r_out_valid && r_out_last && !r_pend_valid))
        else $error("flush did not present final result");

endmodule

### hw/rtl/mcled_ctrl.sv
// Controller: sequences ticks through the divider and walks the channels.
module mcled_ctrl
    import mcled_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic [1:0] i_op,
    output logic      o_ready,
    output t_ctrl_cmd o_cmd,
    input  t_dp_stat  i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_B,
        S_WAIT_B,
        S_DIV_P,
        S_WAIT_P,
        S_FOLD,
        S_DIV_L,
        S_WAIT_L,
        S_CH_LOAD,
        S_CH_EVAL,
        S_FLUSH
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [CH_W-1:0] r_idx;
    logic [CH_W-1:0] n_idx;
    logic            w_last_ch;
    logic            w_blocked;

    assign w_last_ch = (r_idx == CH_W'(CHANNELS - 1));
    assign w_blocked = i_stat.diff && i_stat.pend_valid && !i_stat.out_free;
    assign o_ready   = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        o_cmd           = '0;
        o_cmd.div_sel   = DIV_BLINK;
        o_cmd.idx       = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_op == OP_TICK) begin
                        n_state = S_DIV_B;
                    end
                end
            end
            S_DIV_B: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_BLINK;
                n_state         = S_WAIT_B;
            end
            S_WAIT_B: begin
                if (i_stat.div_done) begin
                    n_state = S_DIV_P;
                end
            end
            S_DIV_P: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_PULSE;
                n_state         = S_WAIT_P;
            end
            S_WAIT_P: begin
                if (i_stat.div_done) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = S_DIV_L;
            end
            S_DIV_L: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_LEVEL;
                n_state         = S_WAIT_L;
            end
            S_WAIT_L: begin
                if (i_stat.div_done) begin
                    n_idx   = '0;
                    n_state = S_CH_LOAD;
                end
            end
            S_CH_LOAD: begin
                if (i_stat.ch_en) begin
                    o_cmd.load_ch = 1'b1;
                    n_state       = S_CH_EVAL;
                end else if (w_last_ch) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx + CH_W'(1);
                end
            end
            S_CH_EVAL: begin
                if (!w_blocked) begin
                    o_cmd.eval = 1'b1;
                    if (w_last_ch) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + CH_W'(1);
                        n_state = S_CH_LOAD;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and channel index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Stay idle while nothing is offered
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_valid) |=> (r_state == S_IDLE))
        else $error("left idle without a transfer");

    // Never commit a change that would overwrite a result still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.eval |-> (!i_stat.diff || !i_stat.pend_valid || i_stat.out_free))
        else $error("evaluation committed while output was full");

endmodule

### tb/sv/mcled_checker.sv
// Scoreboard of the LED effect engine: mirrors channel state and checks each color update.
module mcled_checker
    import mcled_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PER_W-1:0]     i_cfg_wdata,
    mcled_item_if                i_item,
    mcled_result_if              i_result,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last;
    } t_led_update;

    // Mirror of the registers and the per-channel state
    logic [MASK_W-1:0] enable_mask;
    logic [PER_W-1:0]  blink_period;
    logic [PER_W-1:0]  pulse_period;
    logic [RGB_W-1:0]  base_rgb  [CHANNELS];
    logic [1:0]        effect    [CHANNELS];
    logic [RGB_W-1:0]  shown_rgb [CHANNELS];

    t_led_update update_q[$];
    int          mismatches = 0;

    // Periods below the minimum behave as the minimum
    function automatic logic [31:0] clamp_period(logic [PER_W-1:0] p);
        return (p < MIN_PERIOD) ? 32'(MIN_PERIOD) : 32'(p);
    endfunction

    function automatic logic [COLOR_W-1:0] scale_level(logic [COLOR_W-1:0] c, logic [31:0] lvl);
        logic [31:0] prod;
        prod = (32'(c) * lvl) / 32'(FULL_SCALE);
        return prod[COLOR_W-1:0];
    endfunction

    // Color that a channel shows at time now
    function automatic logic [RGB_W-1:0] render(int ch, logic [31:0] now);
        logic [31:0]      per;
        logic [31:0]      half;
        logic [31:0]      ph;
        logic [31:0]      lvl;
        logic [RGB_W-1:0] base;
        base = base_rgb[ch];
        case (effect[ch])
            EFF_SOLID: return base;
            EFF_BLINK: begin
                per = clamp_period(blink_period);
                return ((now % per) < (per >> 1)) ? base : '0;
            end
            EFF_PULSE: begin
                per  = clamp_period(pulse_period);
                half = per >> 1;
                ph   = now % per;
                // fold the falling half of the triangle
                if (ph >= half) ph = per - ph;
                lvl = (ph * 32'(FULL_SCALE)) / half;
                // odd periods overshoot by one step
                if (lvl > 32'(FULL_SCALE)) lvl = 32'(FULL_SCALE);
                return {scale_level(base[23:16], lvl), scale_level(base[15:8], lvl),
                        scale_level(base[7:0], lvl)};
            end
            default: return '0;
        endcase
    endfunction

    // Apply a set-color or set-effect command to the enabled channels it addresses
    function automatic void apply_command(logic [1:0] op, logic [CH_W-1:0] target, logic to_all,
                                          logic [RGB_W-1:0] rgb, logic [1:0] eff);
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (enable_mask[ch] && (to_all || target == CH_W'(ch))) begin
                if (op == OP_SET_COLOR) base_rgb[ch] = rgb;
                else effect[ch] = eff;
            end
        end
    endfunction

    // Queue one update per enabled channel whose color changes, flag the final one
    function automatic void predict_tick(logic [31:0] now);
        logic [RGB_W-1:0] color [CHANNELS];
        logic             changed [CHANNELS];
        int               final_ch;
        t_led_update      upd;
        final_ch = -1;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            changed[ch] = 1'b0;
            color[ch]   = '0;
            if (enable_mask[ch]) begin
                color[ch] = render(ch, now);
                if (color[ch] != shown_rgb[ch]) begin
                    changed[ch]   = 1'b1;
                    shown_rgb[ch] = color[ch];
                    final_ch      = ch;
                end
            end
        end
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (changed[ch]) begin
                upd.channel = CH_W'(ch);
                upd.red     = color[ch][23:16];
                upd.green   = color[ch][15:8];
                upd.blue    = color[ch][7:0];
                upd.last    = (ch == final_ch);
                update_q.push_back(upd);
            end
        end
    endfunction

    // Track register writes, compare result transfers, predict on item transfers
    always @(posedge i_clk) begin
        t_led_update head;
        t_led_update seen;
        seen = '{i_result.channel, i_result.red_out, i_result.green_out,
                 i_result.blue_out, i_result.last};
        if (!i_rst_n) begin
            enable_mask  = '0;
            blink_period = BLINK_RESET;
            pulse_period = PULSE_RESET;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                base_rgb[ch]  = '0;
                effect[ch]    = EFF_OFF;
                shown_rgb[ch] = '1;
            end
            update_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MASK:  enable_mask  = i_cfg_wdata[MASK_W-1:0];
                    CFG_BLINK: blink_period = i_cfg_wdata;
                    CFG_PULSE: pulse_period = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (update_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected update: ch %0d rgb %02h%02h%02h last %0b",
                                 seen.channel, seen.red, seen.green, seen.blue, seen.last);
                end else begin
                    head = update_q.pop_front();
                    if (head !== seen) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("update mismatch: exp ch %0d rgb %02h%02h%02h last %0b, got ch %0d rgb %02h%02h%02h last %0b",
                                     head.channel, head.red, head.green, head.blue, head.last,
                                     seen.channel, seen.red, seen.green, seen.blue, seen.last);
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                case (i_item.op)
                    OP_SET_COLOR, OP_SET_EFFECT:
                        apply_command(i_item.op, i_item.target, i_item.to_all,
                                      {i_item.red_in, i_item.green_in, i_item.blue_in},
                                      i_item.effect_in);
                    OP_TICK: predict_tick(i_item.now_ms);
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= update_q.size();
    end

endmodule

### tb/sv/tb.sv
// Testbench top: clock, reset, register setup, item stimulus, result back-pressure and verdict.
module tb;
    import mcled_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         SETTLE_CYC  = 200;
    localparam int         CYCLE_LIMIT = 300000;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [PER_W-1:0]     cfg_wdata;
    logic                 res_ready = 1'b0;
    bit                   stall_free = 1'b0;
    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    int                   ready_hold = 0;

    mcled_item_if   item_bus ();
    mcled_result_if result_bus ();

    assign result_bus.ready = res_ready;

    multi_channel_led_effect_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_bus),
        .o_result    (result_bus)
    );

    mcled_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_item       (item_bus),
        .i_result     (result_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Hold ready low for a random number of cycles after each result transfer
    always @(posedge i_clk) begin
        int hold_next;
        if (!i_rst_n) hold_next = 0;
        else if (result_bus.valid && result_bus.ready)
            hold_next = stall_free ? 0 : $urandom_range(0, 12);
        else if (ready_hold > 0) hold_next = ready_hold - 1;
        else hold_next = 0;
        ready_hold <= hold_next;
        res_ready  <= (hold_next == 0);
    end

    // Present one item after a random gap and hold it until it transfers
    task automatic send_item(input logic [1:0] op, input logic [CH_W-1:0] target,
                             input logic to_all, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [1:0] eff, input logic [31:0] now);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.op        <= op;
        item_bus.target    <= target;
        item_bus.to_all    <= to_all;
        item_bus.red_in    <= r;
        item_bus.green_in  <= g;
        item_bus.blue_in   <= b;
        item_bus.effect_in <= eff;
        item_bus.now_ms    <= now;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
    endtask

    // Drop valid, drain all expected updates, then let a trailing tick walk finish
    task automatic drain();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] mask, input logic [15:0] blink,
                                input logic [15:0] pulse);
        drain();
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_MASK;
        cfg_wdata <= PER_W'(mask);
        @(posedge i_clk);
        cfg_idx   <= CFG_BLINK;
        cfg_wdata <= blink;
        @(posedge i_clk);
        cfg_idx   <= CFG_PULSE;
        cfg_wdata <= pulse;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_color();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 3));
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(2, 64));
            default: return 16'($urandom_range(2, 3000));
        endcase
    endfunction

    initial begin
        int          sent;
        int          sel;
        logic [31:0] clock_ms;
        logic [31:0] now;
        logic [1:0]  op;

        item_bus.valid     <= 1'b0;
        item_bus.op        <= OP_SET_COLOR;
        item_bus.target    <= '0;
        item_bus.to_all    <= 1'b0;
        item_bus.red_in    <= '0;
        item_bus.green_in  <= '0;
        item_bus.blue_in   <= '0;
        item_bus.effect_in <= EFF_OFF;
        item_bus.now_ms    <= '0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_MASK;
        cfg_wdata          <= '0;
        i_rst_n            <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Tick with reset registers: nothing enabled, nothing shown
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, EFF_OFF, 32'd0);

        // Single channel, minimum periods; first render of white stays silent
        program_regs(8'h80, 16'd0, 16'd1);
        send_item(OP_SET_COLOR, 3'd7, 1'b0, 8'hFF, 8'hFF, 8'hFF, EFF_OFF, 32'd0);
        send_item(OP_SET_EFFECT, 3'd7, 1'b0, 8'h00, 8'h00, 8'h00, EFF_SOLID, 32'd0);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, EFF_OFF, 32'd5);
        send_item(OP_SET_COLOR, 3'd3, 1'b0, 8'h12, 8'h34, 8'h56, EFF_OFF, 32'd0);
        send_item(OP_SET_EFFECT, 3'd0, 1'b1, 8'h00, 8'h00, 8'h00, EFF_BLINK, 32'd0);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, EFF_OFF, 32'd0);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, EFF_OFF, 32'd1);

        // All channels, maximum periods: every effect, saturated pulse, time wrap
        program_regs(8'hFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_SET_COLOR, 3'd0, 1'b1, 8'hFF, 8'h00, 8'hFF, EFF_OFF, 32'd0);
        send_item(OP_SET_EFFECT, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, EFF_SOLID, 32'd0);
        send_item(OP_SET_EFFECT, 3'd1, 1'b0, 8'h00, 8'h00, 8'h00, EFF_BLINK, 32'd0);
        send_item(OP_SET_EFFECT, 3'd2, 1'b0, 8'h00, 8'h00, 8'h00, EFF_PULSE, 32'd0);
        send_item(OP_SET_EFFECT, 3'd3, 1'b0, 8'h00, 8'h00, 8'h00, EFF_OFF, 32'd0);
        send_item(OP_SET_COLOR, 3'd4, 1'b0, 8'h00, 8'hFF, 8'h00, EFF_OFF, 32'd0);
        send_item(OP_SET_EFFECT, 3'd4, 1'b0, 8'h00, 8'h00, 8'h00, EFF_PULSE, 32'd0);
        send_item(OP_UNUSED, 3'd5, 1'b1, 8'hAA, 8'h55, 8'hAA, EFF_PULSE, 32'd77);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, EFF_OFF, 32'd32767);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, EFF_OFF, 32'hFFFF_FFFF);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, EFF_OFF, 32'd16000);

        // Sparse mask, short odd periods
        program_regs(8'h5A, 16'd3, 16'd3);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, EFF_OFF, 32'd1);
        send_item(OP_SET_EFFECT, 3'd0, 1'b1, 8'h00, 8'h00, 8'h00, EFF_PULSE, 32'd0);
        send_item(OP_SET_COLOR, 3'd6, 1'b1, 8'hFF, 8'hFF, 8'hFF, EFF_OFF, 32'd0);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, EFF_OFF, 32'd2);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, EFF_OFF, 32'hFFFF_FFFE);

        // Random phases, each with fresh register values
        for (int phase = 0; phase < 6; phase++) begin
            program_regs((phase == 0) ? 8'hFF : 8'($urandom), pick_period(), pick_period());
            stall_free <= (phase == 2) || ($urandom_range(0, 3) == 0);
            clock_ms = $urandom();
            sent = 0;
            while (sent < 12) begin
                sel = $urandom_range(0, 99);
                if ($urandom_range(0, 1) == 1) begin
                    clock_ms = clock_ms + $urandom_range(0, 60);
                    now = clock_ms;
                end else begin
                    now = $urandom();
                end
                if (sel < 45) op = OP_TICK;
                else if (sel < 70) op = OP_SET_COLOR;
                else if (sel < 95) op = OP_SET_EFFECT;
                else op = OP_UNUSED;
                send_item(op, 3'($urandom), 1'($urandom_range(0, 4) == 0), pick_color(),
                          pick_color(), pick_color(), 2'($urandom), now);
                if (op != OP_UNUSED) sent++;
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/mcled_pkg.sv
hw/rtl/mcled_item_if.sv
hw/rtl/mcled_result_if.sv
hw/rtl/mcled_div.sv
hw/rtl/mcled_dp.sv
hw/rtl/mcled_ctrl.sv
hw/rtl/multi_channel_led_effect_engine.sv
tb/sv/mcled_checker.sv
tb/sv/tb.sv
